// ===== rtl/core/hps_pkg.sv =====
// hps_pkg: shared types, constants and fixed-point helpers for the hydrostatic stress block
// used by every module under rtl/core and by the port checker
package hps_pkg;

    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int QW         = 64;
    localparam int HW         = QW / 2;
    localparam int QM_LAT     = 2;
    // quotient bits below the overflow range, resolved a few per stage
    localparam int DIV_BITS   = QW - 1;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    localparam int DIV_LAT    = DIV_STAGES + 2;
    localparam int N_IN       = 10;
    localparam int IN_W       = N_IN * DATA_W;
    localparam int OUT_W      = 9 * DATA_W;
    localparam int USER_W     = 5;
    localparam int ADDR_W     = 3;

    typedef logic signed [QW-1:0] t_q;
    typedef t_q [8:0] t_mat;
    typedef logic [3:0] t_kind;
    typedef logic [8:0][DATA_W-1:0] t_row;

    localparam t_q QMAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW:0] QMAX_X = {2'b00, {(QW-1){1'b1}}};
    localparam logic signed [QW:0] QMIN_X = -QMAX_X;
    localparam t_q FMAX = t_q'({1'b0, {(DATA_W-1){1'b1}}});
    localparam t_q FMIN = -FMAX - t_q'(1);

    localparam t_kind KIND_STRESS   = 4'd0;
    localparam t_kind KIND_DS       = 4'd1;
    localparam t_kind KIND_DF_FIRST = 4'd2;
    localparam t_kind KIND_DF_LAST  = 4'd10;

    localparam logic REG_EMIT_VALUE = 1'b0;
    localparam logic REG_EMIT_DERIV = 1'b1;

    typedef struct packed {
        logic  v;
        t_kind kind;
        logic  last;
        logic  sing;
    } t_sb;

    typedef struct packed {
        t_q   det;
        t_q   a;
        t_mat finv;
        t_mat cinv;
    } t_item;

    typedef struct packed {
        logic [QW-1:0]       rem;
        logic [DIV_BITS-1:0] num;
        logic [DIV_BITS-1:0] quo;
    } t_dstate;

    function automatic t_q qadd(t_q a, t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        if (s > QMAX_X) return QMAX;
        if (s < QMIN_X) return -QMAX;
        return s[QW-1:0];
    endfunction

    function automatic t_q qneg(t_q x);
        return -x;
    endfunction

    function automatic logic [DATA_W-1:0] to_field(t_q v);
        if (v > FMAX) return FMAX[DATA_W-1:0];
        if (v < FMIN) return FMIN[DATA_W-1:0];
        return v[DATA_W-1:0];
    endfunction

    function automatic t_dstate div_steps(t_dstate st, logic [QW-1:0] d);
        t_dstate       r;
        logic [QW-1:0] x;
        r = st;
        for (int k = 0; k < DIV_STEP; k++) begin
            x = {r.rem[QW-2:0], r.num[DIV_BITS-1]};
            r.num = {r.num[DIV_BITS-2:0], 1'b0};
            if (x >= d) begin
                r.rem = x - d;
                r.quo = {r.quo[DIV_BITS-2:0], 1'b1};
            end else begin
                r.rem = x;
                r.quo = {r.quo[DIV_BITS-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    // derivative row kind to {m, n}
    function automatic logic [3:0] kind_mn(t_kind k);
        logic [3:0] off;
        off = k - KIND_DF_FIRST;
        case (off)
            4'd0:    return {2'd0, 2'd0};
            4'd1:    return {2'd0, 2'd1};
            4'd2:    return {2'd0, 2'd2};
            4'd3:    return {2'd1, 2'd0};
            4'd4:    return {2'd1, 2'd1};
            4'd5:    return {2'd1, 2'd2};
            4'd6:    return {2'd2, 2'd0};
            4'd7:    return {2'd2, 2'd1};
            4'd8:    return {2'd2, 2'd2};
            default: return {2'd0, 2'd0};
        endcase
    endfunction

    function automatic t_q pick(t_mat mt, logic [1:0] r, logic [1:0] c);
        logic [3:0] idx;
        idx = 4'({r, 1'b0}) + 4'(r) + 4'(c);
        return mt[idx];
    endfunction

endpackage

// ===== rtl/core/hydrostatic_pk2_stress_3x3.sv =====
// an input request goes through the front pipeline, is handed over to the row sequencer and
// then goes through the row pipeline to the first row, with the row sequencer idle
// throughput: one row per cycle while the output is not stalled, set by the row sequencer
// issuing one row a cycle into the row pipeline; an item carries at most eleven rows; the front
// pipeline takes one item per cycle while the sequencer keeps up
// reset: synchronous active low, clears all valid bits and sets emit_value 1, emit_derivatives 0
module hydrostatic_pk2_stress_3x3 import hps_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    // f_00 f_01 f_02 f_10 f_11 f_12 f_20 f_21 f_22 stress_offset, 32 bits each from bit 0
    input  logic [IN_W-1:0]   i_s_tdata,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    // out_00 out_01 out_02 out_10 out_11 out_12 out_20 out_21 out_22, 32 bits each
    output logic [OUT_W-1:0]  o_m_tdata,
    // row_kind [3:0], singular [4]
    output logic [USER_W-1:0] o_m_tuser,
    output logic              o_m_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic  r_emit_value, r_emit_deriv;
    logic  cfg_wr;
    t_mat  w_f;
    t_q    w_s;
    logic  item_valid, take;
    t_item item;
    t_kind kind;
    t_row  row;
    logic  sing;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_value <= 1'b1;
            r_emit_deriv <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_EMIT_VALUE) begin
                r_emit_value <= pwdata[0];
            end else begin
                r_emit_deriv <= pwdata[0];
            end
        end
    end

    assign prdata = {31'd0, (paddr[2] == REG_EMIT_VALUE) ? r_emit_value : r_emit_deriv};

    for (genvar k = 0; k < 9; k++) begin : g_unpack
        assign w_f[k] = {{(QW-DATA_W){i_s_tdata[DATA_W*k+DATA_W-1]}},
                         i_s_tdata[DATA_W*k +: DATA_W]};
    end
    assign w_s = {{(QW-DATA_W){i_s_tdata[IN_W-1]}}, i_s_tdata[IN_W-1 -: DATA_W]};

    hps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_f     (w_f),
        .i_s     (w_s),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    hps_rows u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_value (r_emit_value),
        .i_cfg_deriv (r_emit_deriv),
        .i_valid     (item_valid),
        .i_item      (item),
        .o_take      (take),
        .i_ready     (i_m_tready),
        .o_valid     (o_m_tvalid),
        .o_kind      (kind),
        .o_data      (row),
        .o_sing      (sing),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = row;
    assign o_m_tuser = {sing, kind};

endmodule

// ===== rtl/core/hps_qmul.sv =====
// hps_qmul: two-stage Q-format multiplier, 64x64 cut into four 32x32 partial products
// rounds the magnitude half away from zero and saturates; depends on hps_pkg
module hps_qmul import hps_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_a,
    input  t_q   i_b,
    output t_q   o_p
);
    logic [QW-1:0]   mag_a, mag_b;
    logic [QW-1:0]   r_ll, r_lh, r_hl, r_hh;
    logic            r_neg;
    logic [2*QW-1:0] sum, rnd, shf;
    logic [QW-1:0]   mag;
    t_q              n_p, r_p;

    assign mag_a = i_a[QW-1] ? ~i_a + 1'b1 : i_a;
    assign mag_b = i_b[QW-1] ? ~i_b + 1'b1 : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= mag_a[HW-1:0] * mag_b[HW-1:0];
            r_lh  <= mag_a[HW-1:0] * mag_b[QW-1:HW];
            r_hl  <= mag_a[QW-1:HW] * mag_b[HW-1:0];
            r_hh  <= mag_a[QW-1:HW] * mag_b[QW-1:HW];
            r_neg <= i_a[QW-1] ^ i_b[QW-1];
        end
    end

    always_comb begin
        sum = {r_hh, {QW{1'b0}}} + ({{QW{1'b0}}, r_lh} << HW)
            + ({{QW{1'b0}}, r_hl} << HW) + {{QW{1'b0}}, r_ll};
        rnd = sum + ((2*QW)'(1) << (FRAC_W - 1));
        shf = rnd >> FRAC_W;
        mag = (shf[2*QW-1:QW-1] != '0) ? QMAX : shf[QW-1:0];
        n_p = r_neg ? -t_q'(mag) : t_q'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/hps_qdiv.sv =====
// hps_qdiv: pipelined restoring divider for one Q-format quotient, a few bits per stage
// rounds half away from zero and saturates; depends on hps_pkg
module hps_qdiv import hps_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_q   i_num,
    input  t_q   i_den,
    output t_q   o_q
);
    logic [QW-1:0] ma, d;
    t_dstate       st0;
    logic          over0;
    t_dstate       r_st   [0:DIV_STAGES];
    logic [QW-1:0] r_d    [0:DIV_STAGES];
    logic          r_neg  [0:DIV_STAGES];
    logic          r_over [0:DIV_STAGES];
    logic [QW-1:0] qx, mag;
    t_q            n_q, r_q;

    assign ma = i_num[QW-1] ? ~i_num + 1'b1 : i_num;
    assign d  = i_den[QW-1] ? ~i_den + 1'b1 : i_den;

    // the bits of the shifted dividend above the quotient range seed the remainder and flag overflow
    always_comb begin
        st0.rem = ma >> (QW - 1 - FRAC_W);
        st0.num = {ma[QW-2-FRAC_W:0], {FRAC_W{1'b0}}};
        st0.quo = '0;
        over0   = (ma >> (QW - 1 - FRAC_W)) >= d;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0]   <= st0;
            r_d[0]    <= d;
            r_neg[0]  <= i_num[QW-1] ^ i_den[QW-1];
            r_over[0] <= over0;
            for (int k = 1; k <= DIV_STAGES; k++) begin
                r_st[k]   <= div_steps(r_st[k-1], r_d[k-1]);
                r_d[k]    <= r_d[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_over[k] <= r_over[k-1];
            end
        end
    end

    always_comb begin
        qx = {1'b0, r_st[DIV_STAGES].quo}
           + QW'(r_st[DIV_STAGES].rem >= r_d[DIV_STAGES] - r_st[DIV_STAGES].rem);
        if (r_over[DIV_STAGES] || qx > QW'(QMAX)) begin
            mag = QMAX;
        end else begin
            mag = qx;
        end
        n_q = r_neg[DIV_STAGES] ? -t_q'(mag) : t_q'(mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/core/hps_front.sv =====
// hps_front: per-item pipeline from F and s to det, J*s, Finv and Cinv
// built from hps_qmul and hps_qdiv; depends on hps_pkg
module hps_front import hps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_mat  i_f,
    input  t_q    i_s,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);
    logic en;

    logic r_v0;
    t_mat r_f0;
    t_q   r_s0;

    t_mat w_pp, w_pm;
    logic       r_vc   [0:QM_LAT-1];
    t_q         r_sc   [0:QM_LAT-1];
    t_q [2:0]   r_frc  [0:QM_LAT-1];

    logic     r_vC;
    t_q       r_sC;
    t_q [2:0] r_frC;
    t_mat     r_cof;

    t_q [2:0] w_dp;
    logic r_vd  [0:QM_LAT-1];
    t_q   r_sd  [0:QM_LAT-1];
    t_mat r_cd  [0:QM_LAT-1];

    logic r_vD;
    t_q   r_sD;
    t_q   r_det;
    t_mat r_cofD;

    t_mat w_finv;
    logic r_vv  [0:DIV_LAT-1];
    t_q   r_sv  [0:DIV_LAT-1];
    t_q   r_dv  [0:DIV_LAT-1];

    t_q [26:0] w_cp;
    t_q        w_a;
    logic r_vi  [0:QM_LAT-1];
    t_q   r_di  [0:QM_LAT-1];
    t_mat r_fi  [0:QM_LAT-1];

    logic  r_vo;
    t_item r_item;

    assign en      = !r_vo || i_take;
    assign o_ready = en;
    assign o_valid = r_vo;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_vC <= 1'b0;
            r_vD <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k < QM_LAT; k++) begin
                r_vc[k] <= 1'b0;
                r_vd[k] <= 1'b0;
                r_vi[k] <= 1'b0;
            end
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vv[k] <= 1'b0;
            end
        end else if (en) begin
            r_v0    <= i_valid;
            r_vc[0] <= r_v0;
            r_vC    <= r_vc[QM_LAT-1];
            r_vd[0] <= r_vC;
            r_vD    <= r_vd[QM_LAT-1];
            r_vv[0] <= r_vD;
            r_vi[0] <= r_vv[DIV_LAT-1];
            r_vo    <= r_vi[QM_LAT-1];
            for (int k = 1; k < QM_LAT; k++) begin
                r_vc[k] <= r_vc[k-1];
                r_vd[k] <= r_vd[k-1];
                r_vi[k] <= r_vi[k-1];
            end
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vv[k] <= r_vv[k-1];
            end
        end
    end

    // cofactor products
    for (genvar i = 0; i < 3; i++) begin : g_cof_r
        for (genvar j = 0; j < 3; j++) begin : g_cof_c
            localparam int R1 = (i + 1) % 3;
            localparam int R2 = (i + 2) % 3;
            localparam int C1 = (j + 1) % 3;
            localparam int C2 = (j + 2) % 3;
            hps_qmul u_pp (.i_clk(i_clk), .i_en(en), .i_a(r_f0[R1*3+C1]),
                           .i_b(r_f0[R2*3+C2]), .o_p(w_pp[i*3+j]));
            hps_qmul u_pm (.i_clk(i_clk), .i_en(en), .i_a(r_f0[R1*3+C2]),
                           .i_b(r_f0[R2*3+C1]), .o_p(w_pm[i*3+j]));
        end
    end

    for (genvar j = 0; j < 3; j++) begin : g_det
        hps_qmul u_dp (.i_clk(i_clk), .i_en(en), .i_a(r_frC[j]), .i_b(r_cof[j]),
                       .o_p(w_dp[j]));
    end

    // finv(i,j) = cof(j,i) / det
    for (genvar i = 0; i < 3; i++) begin : g_inv_r
        for (genvar j = 0; j < 3; j++) begin : g_inv_c
            hps_qdiv u_div (.i_clk(i_clk), .i_en(en), .i_num(r_cofD[j*3+i]),
                            .i_den(r_det), .o_q(w_finv[i*3+j]));
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_ci_r
        for (genvar j = 0; j < 3; j++) begin : g_ci_c
            for (genvar k = 0; k < 3; k++) begin : g_ci_k
                hps_qmul u_cp (.i_clk(i_clk), .i_en(en), .i_a(w_finv[i*3+k]),
                               .i_b(w_finv[j*3+k]), .o_p(w_cp[(i*3+j)*3+k]));
            end
        end
    end

    hps_qmul u_a (.i_clk(i_clk), .i_en(en), .i_a(r_dv[DIV_LAT-1]),
                  .i_b(r_sv[DIV_LAT-1]), .o_p(w_a));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f0 <= i_f;
            r_s0 <= i_s;

            r_sc[0]  <= r_s0;
            r_frc[0] <= {r_f0[2], r_f0[1], r_f0[0]};
            for (int k = 1; k < QM_LAT; k++) begin
                r_sc[k]  <= r_sc[k-1];
                r_frc[k] <= r_frc[k-1];
            end
            r_sC  <= r_sc[QM_LAT-1];
            r_frC <= r_frc[QM_LAT-1];
            for (int k = 0; k < 9; k++) begin
                r_cof[k] <= qadd(w_pp[k], qneg(w_pm[k]));
            end

            r_sd[0] <= r_sC;
            r_cd[0] <= r_cof;
            for (int k = 1; k < QM_LAT; k++) begin
                r_sd[k] <= r_sd[k-1];
                r_cd[k] <= r_cd[k-1];
            end
            r_sD   <= r_sd[QM_LAT-1];
            r_cofD <= r_cd[QM_LAT-1];
            r_det  <= qadd(qadd(w_dp[0], w_dp[1]), w_dp[2]);

            r_sv[0] <= r_sD;
            r_dv[0] <= r_det;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
                r_dv[k] <= r_dv[k-1];
            end

            r_di[0] <= r_dv[DIV_LAT-1];
            r_fi[0] <= w_finv;
            for (int k = 1; k < QM_LAT; k++) begin
                r_di[k] <= r_di[k-1];
                r_fi[k] <= r_fi[k-1];
            end

            r_item.det  <= r_di[QM_LAT-1];
            r_item.a    <= w_a;
            r_item.finv <= r_fi[QM_LAT-1];
            for (int k = 0; k < 9; k++) begin
                r_item.cinv[k] <= qadd(qadd(w_cp[k*3], w_cp[k*3+1]), w_cp[k*3+2]);
            end
        end
    end

endmodule

// ===== rtl/core/hps_rows.sv =====
// hps_rows: row sequencer and row pipeline, one result row per cycle from a held item
// while the output is not stalled; built from hps_qmul; depends on hps_pkg
module hps_rows import hps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_value,
    input  logic  i_cfg_deriv,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    input  logic  i_ready,
    output logic  o_valid,
    output t_kind o_kind,
    output t_row  o_data,
    output logic  o_sing,
    output logic  o_last
);
    logic  en_r, at_end;
    logic  r_busy, n_busy;
    t_kind r_kind, n_kind;
    t_kind r_end, n_end;
    logic  r_sing, n_sing;
    t_item r_hold;

    logic [3:0] mn;
    logic [1:0] sel_m, sel_n;
    t_mat w_t1, w_t2, w_t3, w_f;

    t_sb  r_sb [0:4];
    t_q   r_x  [0:1];
    t_mat r_ci [0:1];
    t_q   r_x2;
    t_mat r_u;

    logic  r_ov;
    t_kind r_okind;
    t_row  r_odata;
    logic  r_osing, r_olast;

    assign en_r   = !r_ov || i_ready;
    assign at_end = r_kind == r_end;
    assign o_take = i_valid && (!r_busy || (en_r && at_end));

    always_comb begin
        n_busy = r_busy;
        n_kind = r_kind;
        n_end  = r_end;
        n_sing = r_sing;
        if (r_busy && en_r) begin
            if (at_end) begin
                n_busy = 1'b0;
            end else begin
                n_kind = r_kind + 4'd1;
            end
        end
        if (o_take) begin
            n_busy = i_cfg_value || i_cfg_deriv;
            n_sing = i_item.det == '0;
            n_kind = i_cfg_value ? KIND_STRESS : KIND_DS;
            n_end  = (n_sing || !i_cfg_deriv) ? n_kind : KIND_DF_LAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_end  <= n_end;
        r_sing <= n_sing;
        if (o_take) begin
            r_hold <= i_item;
        end
    end

    assign mn    = kind_mn(r_kind);
    assign sel_m = mn[3:2];
    assign sel_n = mn[1:0];

    for (genvar i = 0; i < 3; i++) begin : g_t_r
        for (genvar j = 0; j < 3; j++) begin : g_t_c
            hps_qmul u_t1 (.i_clk(i_clk), .i_en(en_r),
                           .i_a(pick(r_hold.finv, 2'(i), sel_m)),
                           .i_b(pick(r_hold.cinv, sel_n, 2'(j))), .o_p(w_t1[i*3+j]));
            hps_qmul u_t2 (.i_clk(i_clk), .i_en(en_r),
                           .i_a(pick(r_hold.cinv, 2'(i), sel_n)),
                           .i_b(pick(r_hold.finv, 2'(j), sel_m)), .o_p(w_t2[i*3+j]));
            hps_qmul u_t3 (.i_clk(i_clk), .i_en(en_r),
                           .i_a(pick(r_hold.finv, sel_n, sel_m)),
                           .i_b(r_hold.cinv[i*3+j]), .o_p(w_t3[i*3+j]));
            hps_qmul u_f  (.i_clk(i_clk), .i_en(en_r), .i_a(r_x2), .i_b(r_u[i*3+j]),
                           .o_p(w_f[i*3+j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_sb[k].v <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en_r) begin
            r_sb[0] <= '{v: r_busy, kind: r_kind, last: at_end, sing: r_sing};
            for (int k = 1; k < 5; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
            r_ov <= r_sb[4].v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_r) begin
            r_x[0]  <= (r_kind == KIND_DS) ? r_hold.det : r_hold.a;
            r_ci[0] <= r_hold.cinv;
            r_x[1]  <= r_x[0];
            r_ci[1] <= r_ci[0];
            r_x2    <= r_x[1];
            for (int k = 0; k < 9; k++) begin
                if (r_sb[1].kind == KIND_STRESS || r_sb[1].kind == KIND_DS) begin
                    r_u[k] <= r_ci[1][k];
                end else begin
                    r_u[k] <= qadd(qadd(w_t1[k], w_t2[k]), qneg(w_t3[k]));
                end
            end
            r_okind <= r_sb[4].kind;
            r_osing <= r_sb[4].sing;
            r_olast <= r_sb[4].last;
            for (int k = 0; k < 9; k++) begin
                if (r_sb[4].sing) begin
                    r_odata[k] <= '0;
                end else if (r_sb[4].kind == KIND_STRESS || r_sb[4].kind == KIND_DS) begin
                    r_odata[k] <= to_field(qneg(w_f[k]));
                end else begin
                    r_odata[k] <= to_field(w_f[k]);
                end
            end
        end
    end

    assign o_valid = r_ov;
    assign o_kind  = r_okind;
    assign o_data  = r_odata;
    assign o_sing  = r_osing;
    assign o_last  = r_olast;

endmodule

// ===== rtl/core/hps_chk.sv =====
// hps_chk: port-level checker for the result stream of the hydrostatic stress block
// bound to hydrostatic_pk2_stress_3x3; depends on hps_pkg
module hps_chk import hps_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [OUT_W-1:0]  o_m_tdata,
    input logic [USER_W-1:0] o_m_tuser,
    input logic              o_m_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result request changed while stalled");

    a_sing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[4] |-> o_m_tdata == '0 && o_m_tlast)
        else $error("singular row not zero or not last");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser[3:0] <= KIND_DF_LAST)
        else $error("row kind out of range");

    a_lastdf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3:0] == KIND_DF_LAST |-> o_m_tlast)
        else $error("final derivative row not marked last");

endmodule

bind hydrostatic_pk2_stress_3x3 hps_chk u_hps_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
